@@ sv/ethp_pkg.sv @@
// ============================================================================
// ethp_pkg: shared types and constants of the Ethernet/IPv4/TCP header parser
// Request and result structs, result kinds and the header offsets in use.
// ============================================================================
package ethp_pkg;

    // Default size of the Ethernet header in front of the IPv4 header.
    localparam int ETH_HEADER_BYTES_DEF = 14;

    // Result queue depth; the pointers wrap naturally at this power of two.
    localparam int RFIFO_DEPTH = 4;
    localparam int RFIFO_PTR_W = 2;
    localparam int RFIFO_CNT_W = 3;

    // Byte positions saturate at this value and are no longer examined.
    localparam logic [15:0] POS_MAX = 16'hFFFF;

    // Offsets inside the IPv4 header, counted from its first byte.
    localparam logic [15:0] OFF_TOTLEN_HI = 16'd2;
    localparam logic [15:0] OFF_TOTLEN_LO = 16'd3;
    localparam logic [15:0] OFF_SRC_FIRST = 16'd12;
    localparam logic [15:0] OFF_SRC_LAST  = 16'd15;
    localparam logic [15:0] OFF_DST_FIRST = 16'd16;
    localparam logic [15:0] OFF_DST_LAST  = 16'd19;

    // Offsets inside the TCP header, counted from its first byte.
    localparam logic [15:0] TCP_OFF_SPORT_LO = 16'd1;
    localparam logic [15:0] TCP_OFF_DPORT_HI = 16'd2;
    localparam logic [15:0] TCP_OFF_DPORT_LO = 16'd3;
    localparam logic [15:0] TCP_OFF_DOFF     = 16'd12;

    // Smallest legal header length for IPv4 and TCP, in bytes.
    localparam logic [5:0] MIN_HDR_BYTES = 6'd20;

    // Printable character range.
    localparam logic [7:0] CHAR_LOW  = 8'h20;
    localparam logic [7:0] CHAR_HIGH = 8'h7E;

    typedef enum logic [2:0] {
        KIND_ADDR      = 3'd0,
        KIND_PORTS     = 3'd1,
        KIND_CHAR      = 3'd2,
        KIND_BAD_IP    = 3'd3,
        KIND_BAD_TCP   = 3'd4,
        KIND_FRAME_END = 3'd5
    } ethp_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } ethp_in_t;

    typedef struct packed {
        ethp_kind_t  kind;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  text_char;
        logic [31:0] packet_number;
        logic        run_last;
    } ethp_out_t;

    // Results produced by one request: count is 0, 1 or 2, in order.
    typedef struct packed {
        logic [1:0] count;
        ethp_out_t  first;
        ethp_out_t  second;
    } ethp_push_t;

endpackage

@@ sv/ethp_parse.sv @@
// ============================================================================
// ethp_parse: per-byte header decode and frame state
// Tracks the byte position, captures header fields and forms the results
// that each processed byte causes.
// ============================================================================
module ethp_parse #(
    parameter int ETH_HEADER_BYTES = ethp_pkg::ETH_HEADER_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               proc_en,
    input  ethp_pkg::ethp_in_t in_item,
    output ethp_pkg::ethp_push_t push
);
    import ethp_pkg::*;

    localparam logic [15:0] ETH_POS = 16'(ETH_HEADER_BYTES);

    logic [15:0] pos_reg,      pos_next;
    logic [5:0]  iphl_reg,     iphl_next;
    logic [5:0]  tcphl_reg,    tcphl_next;
    logic [15:0] totlen_reg,   totlen_next;
    logic [31:0] src_addr_reg, src_addr_next;
    logic [31:0] dst_addr_reg, dst_addr_next;
    logic [15:0] src_port_reg, src_port_next;
    logic [15:0] dst_port_reg, dst_port_next;
    logic        aborted_reg,  aborted_next;
    logic [31:0] counter_reg,  counter_next;

    logic [7:0]  b;
    logic        active;
    logic [15:0] off;
    logic [15:0] t_ext;
    logic [15:0] pay_start;
    logic [5:0]  ihl_bytes;
    logic [5:0]  doff_bytes;
    logic        prim_valid;
    ethp_kind_t  prim_kind;
    ethp_out_t   prim_res;
    ethp_out_t   end_res;

    function automatic ethp_out_t make_result(
        input ethp_kind_t  kind,
        input logic [31:0] saddr,
        input logic [31:0] daddr,
        input logic [15:0] sport,
        input logic [15:0] dport,
        input logic [7:0]  ch,
        input logic [31:0] num
    );
        ethp_out_t r;
        r.kind           = kind;
        r.source_address = (kind == KIND_ADDR || kind == KIND_PORTS) ? saddr : 32'd0;
        r.dest_address   = (kind == KIND_ADDR || kind == KIND_PORTS) ? daddr : 32'd0;
        r.source_port    = (kind == KIND_PORTS) ? sport : 16'd0;
        r.dest_port      = (kind == KIND_PORTS) ? dport : 16'd0;
        r.text_char      = (kind == KIND_CHAR) ? ch : 8'd0;
        r.packet_number  = num;
        r.run_last       = 1'b0;
        return r;
    endfunction

    // Field extraction and position arithmetic for the current byte.
    assign b          = in_item.data_byte;
    assign active     = !aborted_reg && (pos_reg != POS_MAX);
    assign off        = pos_reg - ETH_POS;
    assign t_ext      = {10'd0, iphl_reg};
    assign pay_start  = t_ext + {10'd0, tcphl_reg};
    assign ihl_bytes  = {b[3:0], 2'b00};
    assign doff_bytes = {b[7:4], 2'b00};

    // Header capture and choice of the result that the byte itself causes.
    always_comb begin
        iphl_next     = iphl_reg;
        tcphl_next    = tcphl_reg;
        totlen_next   = totlen_reg;
        src_addr_next = src_addr_reg;
        dst_addr_next = dst_addr_reg;
        src_port_next = src_port_reg;
        dst_port_next = dst_port_reg;
        aborted_next  = aborted_reg;
        prim_valid    = 1'b0;
        prim_kind     = KIND_CHAR;
        if (active && pos_reg == ETH_POS) begin
            iphl_next = ihl_bytes;
            if (ihl_bytes < MIN_HDR_BYTES) begin
                aborted_next = 1'b1;
                prim_valid   = 1'b1;
                prim_kind    = KIND_BAD_IP;
            end
        end else if (active && pos_reg > ETH_POS) begin
            if (off == OFF_TOTLEN_HI || off == OFF_TOTLEN_LO) begin
                totlen_next = {totlen_reg[7:0], b};
            end
            if (off >= OFF_SRC_FIRST && off <= OFF_SRC_LAST) begin
                src_addr_next = {src_addr_reg[23:0], b};
            end
            if (off >= OFF_DST_FIRST && off <= OFF_DST_LAST) begin
                dst_addr_next = {dst_addr_reg[23:0], b};
            end
            if (off == OFF_DST_LAST) begin
                prim_valid = 1'b1;
                prim_kind  = KIND_ADDR;
            end
            if (off == t_ext || off == t_ext + TCP_OFF_SPORT_LO) begin
                src_port_next = {src_port_reg[7:0], b};
            end
            if (off == t_ext + TCP_OFF_DPORT_HI || off == t_ext + TCP_OFF_DPORT_LO) begin
                dst_port_next = {dst_port_reg[7:0], b};
            end
            if (off == t_ext + TCP_OFF_DOFF) begin
                tcphl_next = doff_bytes;
                prim_valid = 1'b1;
                if (doff_bytes < MIN_HDR_BYTES) begin
                    aborted_next = 1'b1;
                    prim_kind    = KIND_BAD_TCP;
                end else begin
                    prim_kind = KIND_PORTS;
                end
            end else if (tcphl_reg >= MIN_HDR_BYTES && off >= pay_start &&
                         off < totlen_reg && b >= CHAR_LOW && b <= CHAR_HIGH) begin
                prim_valid = 1'b1;
                prim_kind  = KIND_CHAR;
            end
        end
    end

    // Results carry the field values as updated by this byte.
    always_comb begin
        prim_res = make_result(prim_kind, src_addr_next, dst_addr_next,
                               src_port_next, dst_port_next, b, counter_reg);
        end_res  = make_result(KIND_FRAME_END, 32'd0, 32'd0, 16'd0, 16'd0, 8'd0,
                               counter_reg);
        end_res.run_last = 1'b1;
        push.count  = 2'd0;
        push.first  = prim_res;
        push.second = end_res;
        if (proc_en) begin
            if (prim_valid && in_item.frame_end) begin
                push.count = 2'd2;
            end else if (prim_valid) begin
                push.count          = 2'd1;
                push.first.run_last = 1'b1;
            end else if (in_item.frame_end) begin
                push.count = 2'd1;
                push.first = end_res;
            end
        end
    end

    // Position advance, and the return to the clean state at frame end.
    always_comb begin
        pos_next     = (pos_reg != POS_MAX) ? pos_reg + 16'd1 : pos_reg;
        counter_next = counter_reg;
        if (in_item.frame_end) begin
            counter_next = counter_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= 16'd0;
            iphl_reg     <= 6'd0;
            tcphl_reg    <= 6'd0;
            totlen_reg   <= 16'd0;
            src_addr_reg <= 32'd0;
            dst_addr_reg <= 32'd0;
            src_port_reg <= 16'd0;
            dst_port_reg <= 16'd0;
            aborted_reg  <= 1'b0;
            counter_reg  <= 32'd1;
        end else if (proc_en) begin
            counter_reg <= counter_next;
            if (in_item.frame_end) begin
                pos_reg      <= 16'd0;
                iphl_reg     <= 6'd0;
                tcphl_reg    <= 6'd0;
                totlen_reg   <= 16'd0;
                src_addr_reg <= 32'd0;
                dst_addr_reg <= 32'd0;
                src_port_reg <= 16'd0;
                dst_port_reg <= 16'd0;
                aborted_reg  <= 1'b0;
            end else begin
                pos_reg      <= pos_next;
                iphl_reg     <= iphl_next;
                tcphl_reg    <= tcphl_next;
                totlen_reg   <= totlen_next;
                src_addr_reg <= src_addr_next;
                dst_addr_reg <= dst_addr_next;
                src_port_reg <= src_port_next;
                dst_port_reg <= dst_port_next;
                aborted_reg  <= aborted_next;
            end
        end
    end

endmodule

@@ sv/ethp_rfifo.sv @@
// ============================================================================
// ethp_rfifo: result queue
// Takes up to two results per cycle and hands out one per cycle when ready.
// ============================================================================
module ethp_rfifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ethp_pkg::ethp_push_t push,
    output logic                 room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ethp_pkg::ethp_out_t  m_result
);
    import ethp_pkg::*;

    ethp_out_t               mem [RFIFO_DEPTH];
    logic [RFIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [RFIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [RFIFO_CNT_W-1:0]  count_reg,  count_next;
    logic                    pop;

    // Room for a full pair of results, independent of the output side.
    assign room     = count_reg <= RFIFO_CNT_W'(RFIFO_DEPTH - 2);
    assign m_valid  = count_reg != '0;
    assign m_result = mem[rd_ptr_reg];
    assign pop      = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + RFIFO_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + RFIFO_PTR_W'(pop);
        count_next  = count_reg + RFIFO_CNT_W'(push.count) - RFIFO_CNT_W'(pop);
    end

    // Entry writes; the second result goes one slot past the first.
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + RFIFO_PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/eth_ipv4_tcp_header_parser.sv @@
// ============================================================================
// eth_ipv4_tcp_header_parser: Ethernet/IPv4/TCP header parser
// Reports addresses, ports, length errors and printable payload bytes of
// captured frames, and a numbered marker at the end of every frame.
// ============================================================================
//
//  Channel  Ports                       Moves
//  -------  --------------------------  ----------------------------------
//  input    s_valid, s_ready, s_item    one frame byte and its end flag
//  result   m_valid, m_ready, m_result  one result (kind and fields)
//
// A byte is registered on acceptance and decoded from that register once the
// result queue has room; one byte per cycle is sustained while it has room.
// A byte with a result that also ends the frame makes two results, which the
// single output port of the result queue hands out one after the other.
// Reset clears all frame state and sets the packet number to 1; no sweep.
// Once the four-entry result queue holds more than two results, the held
// request waits and further input requests are held off; nothing is dropped.
//
module eth_ipv4_tcp_header_parser #(
    parameter int ETH_HEADER_BYTES = ethp_pkg::ETH_HEADER_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ethp_pkg::ethp_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output ethp_pkg::ethp_out_t m_result
);
    import ethp_pkg::*;

    logic       in_valid_reg, in_valid_next;
    ethp_in_t   in_reg;
    logic       room;
    logic       proc_en;
    ethp_push_t push;

    // A held request is decoded once the queue can take both its results.
    assign proc_en = in_valid_reg && room;
    assign s_ready = !in_valid_reg || room;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (proc_en) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
    end

    ethp_parse #(
        .ETH_HEADER_BYTES(ETH_HEADER_BYTES)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .proc_en (proc_en),
        .in_item (in_reg),
        .push    (push)
    );

    ethp_rfifo u_rfifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    // A held request that is not decoded stays in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !proc_en) |=> (in_valid_reg && $stable(in_reg)))
        else $error("held request lost or changed");

    // Every frame-end marker closes the run of its byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result.kind == KIND_FRAME_END) |-> m_result.run_last)
        else $error("frame-end marker without run_last");

    // Addresses are shown only on address and port results.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result.kind != KIND_ADDR && m_result.kind != KIND_PORTS)
        |-> (m_result.source_address == 32'd0 && m_result.dest_address == 32'd0))
        else $error("address leaked into a result of another kind");

    // Out of reset the result side starts empty.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

@@ tb/eth_ipv4_tcp_header_parser_test.sv @@
// ============================================================================
// eth_ipv4_tcp_header_parser_test: self-checking bench for the header parser
// Feeds captured frames byte by byte (a short directed table, then random
// frames, well-formed ones mostly) and checks every report against an
// in-bench decoder of the frame or against the table's typed reports.
// ============================================================================
module eth_ipv4_tcp_header_parser_test;
    import ethp_pkg::*;

    localparam int ETH_BYTES        = ETH_HEADER_BYTES_DEF;
    localparam int CYCLE_LIMIT      = 2_000_000;
    localparam int ITEM_BUDGET      = 160;
    localparam int SHOWN_FAILS      = 10;
    localparam int DRAIN_CYCLES     = 20;

    // One row of the directed table; n_typed < 0 leaves the row to the decoder.
    typedef struct {
        logic [7:0] data;
        logic       last;
        int         n_typed;
        ethp_out_t  rep_a;
        ethp_out_t  rep_b;
    } drow_t;

    logic      aclk     = 1'b0;
    logic      aresetn  = 1'b0;
    logic      s_valid  = 1'b0;
    logic      s_ready;
    ethp_in_t  s_item   = '0;
    logic      m_valid;
    logic      m_ready  = 1'b0;
    ethp_out_t m_result;

    always #5 aclk = ~aclk;

    eth_ipv4_tcp_header_parser uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    // Decoder state: a private copy of the parser's frame state.
    logic [15:0] pr_pos;
    logic [5:0]  pr_ip_hlen;
    logic [5:0]  pr_tcp_hlen;
    logic [15:0] pr_totlen;
    logic [31:0] pr_src;
    logic [31:0] pr_dst;
    logic [15:0] pr_sport;
    logic [15:0] pr_dport;
    logic        pr_dead;
    logic [31:0] pr_pkt;

    ethp_out_t  due_reports[$];
    ethp_out_t  new_reports[$];
    logic [7:0] frame_bytes[$];

    int  fail_count   = 0;
    int  reports_seen = 0;
    int  bytes_sent   = 0;
    int  frames_sent  = 0;
    int  cycles       = 0;
    int  kind_seen[0:7];
    bit  calm         = 1'b0;
    int  sink_left    = 0;
    bit  sink_on      = 1'b0;

    function automatic void note_fail(string msg);
        fail_count++;
        if (fail_count <= SHOWN_FAILS)
            $display("MISMATCH: %s", msg);
    endfunction

    function automatic void clear_parse_state();
        pr_pos      = '0;
        pr_ip_hlen  = '0;
        pr_tcp_hlen = '0;
        pr_totlen   = '0;
        pr_src      = '0;
        pr_dst      = '0;
        pr_sport    = '0;
        pr_dport    = '0;
        pr_dead     = 1'b0;
    endfunction

    // Report built from the current decoder state.
    function automatic ethp_out_t make_report(ethp_kind_t k, logic [7:0] ch);
        ethp_out_t r;
        r = '0;
        r.kind = k;
        if (k == KIND_ADDR || k == KIND_PORTS) begin
            r.source_address = pr_src;
            r.dest_address   = pr_dst;
        end
        if (k == KIND_PORTS) begin
            r.source_port = pr_sport;
            r.dest_port   = pr_dport;
        end
        if (k == KIND_CHAR)
            r.text_char = ch;
        r.packet_number = pr_pkt;
        return r;
    endfunction

    // Report written out by hand for the directed table.
    function automatic ethp_out_t typed_report(ethp_kind_t k, logic [31:0] pn, logic rl);
        ethp_out_t r;
        r = '0;
        r.kind          = k;
        r.packet_number = pn;
        r.run_last      = rl;
        return r;
    endfunction

    function automatic drow_t drow(logic [7:0] d, logic l, int n,
                                   ethp_out_t a = '0, ethp_out_t b = '0);
        drow_t r;
        r.data    = d;
        r.last    = l;
        r.n_typed = n;
        r.rep_a   = a;
        r.rep_b   = b;
        return r;
    endfunction

    // Decode one accepted frame byte; the reports it causes go to new_reports.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        int        off;
        int        t;
        ethp_out_t r;
        new_reports.delete();
        if (!pr_dead && pr_pos != POS_MAX) begin
            if (pr_pos == ETH_BYTES) begin
                pr_ip_hlen = {b[3:0], 2'b00};
                if (pr_ip_hlen < MIN_HDR_BYTES) begin
                    pr_dead = 1'b1;
                    new_reports.push_back(make_report(KIND_BAD_IP, 8'h00));
                end
            end else if (pr_pos > ETH_BYTES) begin
                off = int'(pr_pos) - ETH_BYTES;
                t   = int'(pr_ip_hlen);
                if (off == OFF_TOTLEN_HI || off == OFF_TOTLEN_LO)
                    pr_totlen = {pr_totlen[7:0], b};
                if (off >= OFF_SRC_FIRST && off <= OFF_SRC_LAST)
                    pr_src = {pr_src[23:0], b};
                if (off >= OFF_DST_FIRST && off <= OFF_DST_LAST)
                    pr_dst = {pr_dst[23:0], b};
                if (off == OFF_DST_LAST)
                    new_reports.push_back(make_report(KIND_ADDR, 8'h00));
                if (off == t || off == t + TCP_OFF_SPORT_LO)
                    pr_sport = {pr_sport[7:0], b};
                if (off == t + TCP_OFF_DPORT_HI || off == t + TCP_OFF_DPORT_LO)
                    pr_dport = {pr_dport[7:0], b};
                if (off == t + TCP_OFF_DOFF) begin
                    pr_tcp_hlen = {b[7:4], 2'b00};
                    if (pr_tcp_hlen < MIN_HDR_BYTES) begin
                        pr_dead = 1'b1;
                        new_reports.push_back(make_report(KIND_BAD_TCP, 8'h00));
                    end else begin
                        new_reports.push_back(make_report(KIND_PORTS, 8'h00));
                    end
                end else if (pr_tcp_hlen >= MIN_HDR_BYTES &&
                             off >= t + int'(pr_tcp_hlen) &&
                             off < int'(pr_totlen) &&
                             b >= CHAR_LOW && b <= CHAR_HIGH) begin
                    new_reports.push_back(make_report(KIND_CHAR, b));
                end
            end
        end

        if (pr_pos != POS_MAX)
            pr_pos = pr_pos + 16'd1;

        // The closing byte is decoded first, then the frame is numbered off.
        if (last) begin
            new_reports.push_back(make_report(KIND_FRAME_END, 8'h00));
            pr_pkt = pr_pkt + 32'd1;
            clear_parse_state();
        end

        if (new_reports.size() > 0) begin
            r = new_reports.pop_back();
            r.run_last = 1'b1;
            new_reports.push_back(r);
        end
    endtask

    // Idle gap before a request: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Payload byte biased toward the printable range and its borders.
    function automatic logic [7:0] payload_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 8'($urandom_range(32'h20, 32'h7E));
        if (r < 75) begin
            case ($urandom_range(0, 3))
                0: return 8'h1F;
                1: return CHAR_LOW;
                2: return CHAR_HIGH;
                default: return 8'h7F;
            endcase
        end
        return 8'($urandom);
    endfunction

    // Header filler: whole frames of zeros or ones reach the field extremes.
    function automatic logic [7:0] hdr_byte(int fill);
        if (fill == 0)
            return 8'h00;
        if (fill == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // Present one request and hold it until it is taken. Called at a rising edge.
    task automatic push_byte(input logic [7:0] b, input logic last);
        int   gap;
        logic took;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= {b, last};
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
            decode_byte(frame_bytes[i], i == frame_bytes.size() - 1);
            foreach (new_reports[j])
                due_reports.push_back(new_reports[j]);
        end
        frames_sent++;
    endtask

    // Random frame: well-formed mostly, else short headers or cut short.
    task automatic build_frame();
        int style;
        int fill;
        int ihl;
        int doff;
        int iph;
        int tcph;
        int plen;
        int exact;
        int tot;
        int r;
        int cut;
        frame_bytes.delete();
        style = $urandom_range(0, 99);
        fill  = $urandom_range(0, 9);
        ihl   = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(5, 15);
        doff  = ($urandom_range(0, 9) < 6) ? 5 : $urandom_range(5, 15);
        if (style >= 70 && style < 80)
            ihl = $urandom_range(0, 4);
        if (style >= 80 && style < 90)
            doff = $urandom_range(0, 4);
        iph   = (ihl < 5) ? 20 : ihl * 4;
        tcph  = (doff < 5) ? 20 : doff * 4;
        plen  = $urandom_range(0, 24);
        exact = iph + tcph + plen;

        // Total length: exact, too small, past the capture, or anything.
        r = $urandom_range(0, 99);
        if (r < 60)
            tot = exact;
        else if (r < 75)
            tot = $urandom_range(0, exact);
        else if (r < 90)
            tot = exact + $urandom_range(1, 10);
        else
            tot = $urandom_range(0, 16'hFFFF);

        repeat (ETH_BYTES) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back({4'($urandom), 4'(ihl)});
        frame_bytes.push_back(hdr_byte(fill));
        frame_bytes.push_back(8'(tot >> 8));
        frame_bytes.push_back(8'(tot));
        repeat (iph - 4) frame_bytes.push_back(hdr_byte(fill));
        repeat (12) frame_bytes.push_back(hdr_byte(fill));
        frame_bytes.push_back({4'(doff), 4'($urandom)});
        repeat (tcph - 13) frame_bytes.push_back(hdr_byte(fill));
        repeat (plen) frame_bytes.push_back(payload_char());
        if ($urandom_range(0, 9) < 3)
            repeat ($urandom_range(1, 6)) frame_bytes.push_back(payload_char());

        if (style >= 90) begin
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut)
                void'(frame_bytes.pop_back());
        end
    endtask

    // Result side: ready in bursts, with short and occasional long stalls.
    always @(posedge aclk) begin : result_sink
        int r;
        if (sink_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                sink_on   = 1'b1;
                sink_left = $urandom_range(1, 8);
            end else if (r < 63) begin
                sink_on   = 1'b1;
                sink_left = $urandom_range(50, 200);
            end else if (r < 88) begin
                sink_on   = 1'b0;
                sink_left = $urandom_range(1, 3);
            end else if (r < 97) begin
                sink_on   = 1'b0;
                sink_left = $urandom_range(4, 12);
            end else begin
                sink_on   = 1'b0;
                sink_left = $urandom_range(30, 80);
            end
        end
        sink_left--;
        m_ready <= sink_on;
    end

    // Compare each report taken at the coming edge with the oldest one due.
    always @(negedge aclk) begin : result_check
        ethp_out_t want;
        string     diffs;
        if (aresetn && m_valid && m_ready) begin
            reports_seen++;
            kind_seen[m_result.kind]++;
            if (due_reports.size() == 0) begin
                note_fail($sformatf("report %0d with none due: kind %0d packet %0d",
                                    reports_seen, m_result.kind, m_result.packet_number));
            end else begin
                want  = due_reports.pop_front();
                diffs = "";
                if (m_result.kind !== want.kind)
                    diffs = {diffs, $sformatf(" kind %0d/%0d", want.kind, m_result.kind)};
                if (m_result.source_address !== want.source_address)
                    diffs = {diffs, $sformatf(" src %h/%h", want.source_address,
                                              m_result.source_address)};
                if (m_result.dest_address !== want.dest_address)
                    diffs = {diffs, $sformatf(" dst %h/%h", want.dest_address,
                                              m_result.dest_address)};
                if (m_result.source_port !== want.source_port)
                    diffs = {diffs, $sformatf(" sport %h/%h", want.source_port,
                                              m_result.source_port)};
                if (m_result.dest_port !== want.dest_port)
                    diffs = {diffs, $sformatf(" dport %h/%h", want.dest_port,
                                              m_result.dest_port)};
                if (m_result.text_char !== want.text_char)
                    diffs = {diffs, $sformatf(" char %h/%h", want.text_char,
                                              m_result.text_char)};
                if (m_result.packet_number !== want.packet_number)
                    diffs = {diffs, $sformatf(" packet %0d/%0d", want.packet_number,
                                              m_result.packet_number)};
                if (m_result.run_last !== want.run_last)
                    diffs = {diffs, $sformatf(" last %b/%b", want.run_last,
                                              m_result.run_last)};
                if (diffs != "")
                    note_fail($sformatf("report %0d (expected/actual):%s",
                                        reports_seen, diffs));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d reports still due.",
                     cycles, due_reports.size());
            $display("eth_ipv4_tcp_header_parser_test NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        drow_t rows[$];
        foreach (kind_seen[k])
            kind_seen[k] = 0;
        clear_parse_state();
        pr_pkt = 32'd1;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: lone frame end, short IP header, extreme bytes, a stub.
        rows.push_back(drow(8'h00, 1'b1, 1, typed_report(KIND_FRAME_END, 32'd1, 1'b1)));
        for (int k = 0; k < ETH_BYTES; k++)
            rows.push_back(drow(8'hFF, 1'b0, 0));
        rows.push_back(drow(8'h41, 1'b1, 2, typed_report(KIND_BAD_IP, 32'd2, 1'b0),
                            typed_report(KIND_FRAME_END, 32'd2, 1'b1)));
        rows.push_back(drow(8'hFF, 1'b1, 1, typed_report(KIND_FRAME_END, 32'd3, 1'b1)));
        rows.push_back(drow(8'h00, 1'b0, -1));
        rows.push_back(drow(8'h80, 1'b0, -1));
        rows.push_back(drow(8'h7F, 1'b0, -1));
        rows.push_back(drow(8'h01, 1'b0, -1));
        rows.push_back(drow(8'hFE, 1'b0, -1));
        rows.push_back(drow(8'h40, 1'b0, -1));
        rows.push_back(drow(8'h20, 1'b1, -1));

        foreach (rows[i]) begin
            push_byte(rows[i].data, rows[i].last);
            decode_byte(rows[i].data, rows[i].last);
            if (rows[i].n_typed < 0) begin
                foreach (new_reports[j])
                    due_reports.push_back(new_reports[j]);
            end else begin
                if (rows[i].n_typed > 0)
                    due_reports.push_back(rows[i].rep_a);
                if (rows[i].n_typed > 1)
                    due_reports.push_back(rows[i].rep_b);
            end
        end
        frames_sent += 4;

        // Random frames, some of them sent back to back; the last one is cut
        // short so that the byte count lands on the budget.
        while (bytes_sent < ITEM_BUDGET) begin
            calm = ($urandom_range(0, 4) == 0);
            build_frame();
            while (frame_bytes.size() > ITEM_BUDGET - bytes_sent)
                void'(frame_bytes.pop_back());
            send_frame();
        end
        s_valid <= 1'b0;

        while (due_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d frames in %0d bytes; %0d reports checked.",
                 frames_sent, bytes_sent, reports_seen);
        $display("By kind: addr %0d, ports %0d, char %0d, ip len %0d, tcp len %0d, end %0d.",
                 kind_seen[KIND_ADDR], kind_seen[KIND_PORTS], kind_seen[KIND_CHAR],
                 kind_seen[KIND_BAD_IP], kind_seen[KIND_BAD_TCP], kind_seen[KIND_FRAME_END]);
        if (fail_count == 0) begin
            $display("eth_ipv4_tcp_header_parser_test OK");
        end else begin
            $display("%0d mismatches in total.", fail_count);
            $display("eth_ipv4_tcp_header_parser_test NOT OK");
        end
        $finish;
    end

endmodule
